@@ hw/rtl/keyed_value_table_with_capture_log_assert.svh @@
// Assertion macros used by the keyed value table checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef KEYED_VALUE_TABLE_WITH_CAPTURE_LOG_ASSERT_SVH
`define KEYED_VALUE_TABLE_WITH_CAPTURE_LOG_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVTCL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KVTCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/kvtcl_pkg.sv @@
// Shared types and codes for the keyed value table with capture log.
// No dependencies; used by the top level and its checker.
package kvtcl_pkg;

	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_SET   = 2'd1,
		FN_GET   = 2'd2,
		FN_FLUSH = 2'd3
	} kvtcl_func_t;

	typedef enum logic [1:0] {
		KD_GET   = 2'd0,
		KD_COUNT = 2'd1,
		KD_VALUE = 2'd2
	} kvtcl_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_KEYS = 1'd0,
		CFG_LOG_LIMIT   = 1'd1
	} kvtcl_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GET_OUT,
		ST_FL_CNT,
		ST_FL_RD,
		ST_FL_VAL
	} kvtcl_state_t;

endpackage

@@ hw/rtl/keyed_value_table_with_capture_log.sv @@
// Keyed value table with capture log: a load item is done as it is taken; a get or set scans
// one slot per cycle through the single key comparator and the key and value memories'
// read port, a set over every active slot and a get until it stops at its first match
// (with no active slot a set scans nothing and a get goes straight to its answer); a flush
// sends the count, then reads and sends each logged value in turn, paced by the log
// memory's registered read port. A stalled result register adds its stall to a get or
// flush. One item is worked on at a time and in_stall is high meanwhile; a finished
// result waits in the output register while the next item is taken.
// Depends on kvtcl_pkg.
module keyed_value_table_with_capture_log
	import kvtcl_pkg::*;
#(
	parameter int MAX_KEYS  = 32,
	parameter int LOG_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [4:0]           slot,
	input  logic signed [15:0]   key,
	input  logic signed [31:0]   data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic signed [31:0]   result,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW  = $clog2(MAX_KEYS + 1);
	localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int LCW = $clog2(LOG_DEPTH + 1);
	localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

	kvtcl_state_t state_q, state_d;

	logic [CFG_W-1:0] active_keys_q, log_limit_q;

	kvtcl_func_t func_q;
	logic [15:0]     key_q;
	logic [31:0]     data_q;
	logic [CW-1:0]   n_q, idx_q;
	logic [LCW-1:0]  lim_q, log_count_q, flush_cnt_q, fidx_q;
	logic [31:0]     found_q, log_rd_q;
	logic [MAX_KEYS-1:0] val_vld_q;

	logic [15:0] key_mem [MAX_KEYS];
	logic [31:0] val_mem [MAX_KEYS];
	logic [31:0] log_mem [LOG_DEPTH];

	logic          scan_v_s1, vld_s1;
	logic [AW-1:0] idx_s1;
	logic [15:0]   key_s1;
	logic [31:0]   val_s1;

	logic        out_valid_q, last_q;
	kvtcl_kind_t kind_q;
	logic [31:0] result_q;

	kvtcl_func_t    in_func;
	logic           accept_in, load_ok, issue, hit, set_hit, log_room, out_free;
	logic           scan_done, fl_last;
	logic [AW-1:0]  load_addr;
	logic [CW-1:0]  acc_n;
	logic [LCW-1:0] acc_lim;

	logic        out_load, log_rd_en, out_last_d;
	kvtcl_kind_t out_kind_d;
	logic [31:0] out_result_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept_in = in_valid && !in_stall;
	assign in_func   = kvtcl_func_t'(func);
	assign load_ok   = (32'(slot) < MAX_KEYS);
	assign load_addr = AW'(slot);

	// Out-of-range register values are clamped when the item is taken.
	assign acc_n   = (32'(active_keys_q) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(active_keys_q);
	assign acc_lim = (32'(log_limit_q) > LOG_DEPTH) ? LCW'(LOG_DEPTH) : LCW'(log_limit_q);

	assign issue     = (state_q == ST_SCAN) && (idx_q < n_q);
	assign hit       = scan_v_s1 && (state_q == ST_SCAN) && (key_s1 == key_q);
	assign set_hit   = hit && (func_q == FN_SET);
	assign log_room  = (log_count_q < lim_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_done = (state_q == ST_SCAN) && !issue && !scan_v_s1;
	assign fl_last   = ((fidx_q + LCW'(1)) == flush_cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					case (in_func)
						FN_SET:   state_d = (acc_n == '0) ? ST_IDLE : ST_SCAN;
						FN_GET:   state_d = (acc_n == '0) ? ST_GET_OUT : ST_SCAN;
						FN_FLUSH: state_d = ST_FL_CNT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit && func_q == FN_GET) begin
					state_d = ST_GET_OUT;
				end else if (scan_done) begin
					state_d = (func_q == FN_GET) ? ST_GET_OUT : ST_IDLE;
				end
			end
			ST_GET_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_FL_CNT: begin
				if (out_free) state_d = (flush_cnt_q == '0) ? ST_IDLE : ST_FL_RD;
			end
			ST_FL_RD: state_d = ST_FL_VAL;
			ST_FL_VAL: begin
				if (out_free) state_d = fl_last ? ST_IDLE : ST_FL_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_load     = 1'b0;
		log_rd_en    = 1'b0;
		out_kind_d   = KD_GET;
		out_result_d = found_q;
		out_last_d   = 1'b1;
		case (state_q)
			ST_GET_OUT: begin
				out_load = out_free;
			end
			ST_FL_CNT: begin
				out_load     = out_free;
				out_kind_d   = KD_COUNT;
				out_result_d = 32'(flush_cnt_q);
				out_last_d   = (flush_cnt_q == '0);
			end
			ST_FL_RD: begin
				log_rd_en = 1'b1;
			end
			ST_FL_VAL: begin
				out_load     = out_free;
				out_kind_d   = KD_VALUE;
				out_result_d = log_rd_q;
				out_last_d   = fl_last;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_keys_q <= '0;
			log_limit_q   <= CFG_W'(32);
			log_count_q   <= '0;
			val_vld_q     <= '0;
			idx_q         <= '0;
			fidx_q        <= '0;
			scan_v_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				case (kvtcl_cfg_t'(cfg_index))
					CFG_ACTIVE_KEYS: active_keys_q <= cfg_data;
					CFG_LOG_LIMIT:   log_limit_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept_in) begin
				idx_q  <= '0;
				fidx_q <= '0;
				if (in_func == FN_FLUSH) log_count_q <= '0;
				// A value that is not valid reads as zero, so a load clears it here.
				if (in_func == FN_LOAD && load_ok) val_vld_q[load_addr] <= 1'b0;
			end
			if (issue) idx_q <= idx_q + CW'(1);
			if (set_hit) begin
				val_vld_q[idx_s1] <= 1'b1;
				if (log_room) log_count_q <= log_count_q + LCW'(1);
			end
			if (state_q == ST_FL_VAL && out_free) fidx_q <= fidx_q + LCW'(1);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_q      <= in_func;
			key_q       <= key;
			data_q      <= data;
			n_q         <= acc_n;
			lim_q       <= acc_lim;
			flush_cnt_q <= log_count_q;
			found_q     <= '1;
		end
		if (hit && func_q == FN_GET) found_q <= vld_s1 ? val_s1 : '0;
		if (out_load) begin
			kind_q   <= out_kind_d;
			result_q <= out_result_d;
			last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && in_func == FN_LOAD && load_ok) key_mem[load_addr] <= key;
		if (issue) key_s1 <= key_mem[idx_q[AW-1:0]];
	end

	// The write address trails the read address by one slot, so they never collide.
	always_ff @(posedge clk) begin
		if (set_hit) val_mem[idx_s1] <= data_q;
		if (issue) begin
			val_s1 <= val_mem[idx_q[AW-1:0]];
			vld_s1 <= val_vld_q[idx_q[AW-1:0]];
			idx_s1 <= idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (set_hit && log_room) log_mem[log_count_q[LAW-1:0]] <= data_q;
		if (log_rd_en) log_rd_q <= log_mem[fidx_q[LAW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign result    = result_q;
	assign last      = last_q;

endmodule

@@ hw/rtl/kvtcl_checker.sv @@
// Port-level checks on the result channel of the keyed value table.
// Depends on kvtcl_pkg and keyed_value_table_with_capture_log_assert.svh; bound to the top.
`include "keyed_value_table_with_capture_log_assert.svh"

module kvtcl_checker
	import kvtcl_pkg::*;
#(
	parameter int LOG_DEPTH = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         kind,
	input logic signed [31:0] result,
	input logic               last
);

	`KVTCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(result) && $stable(last), "stalled result changed")
	`KVTCL_ASSERT_SAME(a_get_last, out_valid && kind == KD_GET, last, "get answer without last mark")
	`KVTCL_ASSERT_SAME(a_cnt_last, out_valid && kind == KD_COUNT, last == (result == 0), "flush count last mark wrong")
	`KVTCL_ASSERT_SAME(a_cnt_range, out_valid && kind == KD_COUNT, $unsigned(result) <= 32'(LOG_DEPTH), "flush count above log depth")

endmodule

bind keyed_value_table_with_capture_log kvtcl_checker #(.LOG_DEPTH(LOG_DEPTH)) u_kvtcl_checker (.*);

@@ bench/tb_keyed_value_table_with_capture_log.sv @@
// Self-checking testbench for keyed_value_table_with_capture_log: directed and random
// load, set, get and flush traffic checked against a behavioral table model.
// Depends on kvtcl_pkg and the block's RTL only.
module tb_keyed_value_table_with_capture_log;
	timeunit 1ns;
	timeprecision 1ps;

	import kvtcl_pkg::*;

	localparam int SLOTS         = 32;
	localparam int LOG_SLOTS     = 32;
	localparam int SETTLE_CYCLES = 80;
	localparam int END_CYCLES    = 100;

	typedef struct {
		kvtcl_kind_t kind;
		logic [31:0] value;
		logic        last;
	} answer_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [1:0]           func      = FN_LOAD;
	logic [4:0]           slot      = '0;
	logic signed [15:0]   key       = '0;
	logic signed [31:0]   data      = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           kind;
	logic signed [31:0]   result;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ACTIVE_KEYS;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Table model state.
	logic [15:0] model_keys [SLOTS];
	logic [31:0] model_values [SLOTS];
	logic [31:0] model_log [LOG_SLOTS];
	int          model_log_count;
	logic [5:0]  active_cfg;
	logic [5:0]  limit_cfg;

	answer_t     pending_answers[$];
	int          mismatches;
	logic [15:0] key_pool [8];

	int in_gap_pct     = 20;
	int out_stall_pct  = 20;
	int hold_request   = 0;
	int hold_left      = 0;
	int stall_run      = 0;

	keyed_value_table_with_capture_log dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.slot      (slot),
		.key       (key),
		.data      (data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.result    (result),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Most idle stretches are short, a few are long.
	function automatic int burst_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int idle_len(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		return burst_len();
	endfunction

	function automatic void push_answer(kvtcl_kind_t k, logic [31:0] v, logic l);
		answer_t a;
		a.kind = k;
		a.value = v;
		a.last = l;
		pending_answers.push_back(a);
	endfunction

	function automatic void reset_table_model();
		for (int i = 0; i < SLOTS; i++) begin
			model_keys[i] = '0;
			model_values[i] = '0;
		end
		for (int i = 0; i < LOG_SLOTS; i++)
			model_log[i] = '0;
		model_log_count = 0;
		active_cfg = 6'd0;
		limit_cfg = 6'd32;
	endfunction

	// Applies one accepted item to the table model and queues the answers it causes.
	function automatic void table_step(kvtcl_func_t f, logic [4:0] s, logic [15:0] k,
			logic [31:0] d);
		int n;
		int lim;
		logic [31:0] found;
		n = (active_cfg > SLOTS) ? SLOTS : active_cfg;
		lim = (limit_cfg > LOG_SLOTS) ? LOG_SLOTS : limit_cfg;
		case (f)
			FN_LOAD: begin
				model_keys[s] = k;
				model_values[s] = '0;
			end
			FN_SET: begin
				for (int i = 0; i < n; i++) begin
					if (model_keys[i] == k) begin
						model_values[i] = d;
						if (model_log_count < lim) begin
							model_log[model_log_count] = d;
							model_log_count++;
						end
					end
				end
			end
			FN_GET: begin
				found = 32'hFFFF_FFFF;
				for (int i = 0; i < n; i++) begin
					if (model_keys[i] == k) begin
						found = model_values[i];
						break;
					end
				end
				push_answer(KD_GET, found, 1'b1);
			end
			default: begin
				push_answer(KD_COUNT, model_log_count, model_log_count == 0);
				for (int i = 0; i < model_log_count; i++)
					push_answer(KD_VALUE, model_log[i], i == model_log_count - 1);
				model_log_count = 0;
			end
		endcase
	endfunction

	// Result checker: every output transfer is matched against the oldest answer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result: kind %0d result %h last %0d", kind, result, last);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					mismatches++;
				end
				if (result !== want.value) begin
					$error("result: expected %h, actual %h", want.value, result);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold counted here when one is requested.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
		end else if ($urandom_range(0, 99) < out_stall_pct) begin
			out_stall <= 1'b1;
			stall_run = burst_len();
		end else begin
			out_stall <= 1'b0;
			stall_run = $urandom_range(0, 6);
		end
	end

	// Valid stays high into the next call when no gap is drawn.
	task automatic send_item(kvtcl_func_t f, logic [4:0] s, logic [15:0] k, logic [31:0] d);
		int gap;
		in_valid <= 1'b1;
		func <= f;
		slot <= s;
		key <= k;
		data <= d;
		do @(posedge clk); while (in_stall !== 1'b0);
		table_step(f, s, k, d);
		gap = idle_len(in_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Always waits on the clock before checking, so the next drive lands in a later time step.
	task automatic wait_for_answers();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	// A set or load leaves no answer behind, so allow the block time to finish it.
	task automatic settle();
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [5:0] act, logic [5:0] lim);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ACTIVE_KEYS;
		cfg_data <= act;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		active_cfg = act;
		cfg_index <= CFG_LOG_LIMIT;
		cfg_data <= lim;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		limit_cfg = lim;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_key(int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return key_pool[$urandom_range(0, 7)];
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [31:0] pick_data();
		case ($urandom_range(0, 39))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic test_reset_state();
		// No slot is active after reset, so nothing can match.
		send_item(FN_GET, 5'd0, 16'h0000, 32'h0);
		send_item(FN_SET, 5'd0, 16'h0000, 32'h5);
		send_item(FN_FLUSH, 5'd0, 16'h0000, 32'h0);
		settle();
	endtask

	task automatic test_key_extremes();
		set_config(6'd3, 6'd32);
		send_item(FN_LOAD, 5'd0, 16'h8000, 32'h0);
		send_item(FN_LOAD, 5'd1, 16'h7FFF, 32'h0);
		send_item(FN_LOAD, 5'd2, 16'h7FFF, 32'h0);
		send_item(FN_LOAD, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(FN_GET, 5'd0, 16'h7FFF, 32'h0);
		send_item(FN_SET, 5'd0, 16'h7FFF, 32'h8000_0000);
		send_item(FN_GET, 5'd0, 16'h7FFF, 32'h0);
		send_item(FN_SET, 5'd0, 16'h8000, 32'h7FFF_FFFF);
		send_item(FN_GET, 5'd0, 16'h8000, 32'h0);
		// Slot 31 lies outside the active range.
		send_item(FN_GET, 5'd0, 16'hFFFF, 32'h0);
		send_item(FN_FLUSH, 5'd0, 16'h0000, 32'h0);
	endtask

	task automatic test_minus_one_value();
		// A stored all-ones value cannot be told apart from a miss.
		send_item(FN_SET, 5'd0, 16'h8000, 32'hFFFF_FFFF);
		send_item(FN_GET, 5'd0, 16'h8000, 32'h0);
		send_item(FN_GET, 5'd0, 16'h1234, 32'h0);
	endtask

	task automatic test_limit_below_count();
		send_item(FN_SET, 5'd0, 16'h7FFF, 32'h1111_1111);
		settle();
		// The log now holds more than the new limit; those entries must survive.
		set_config(6'd3, 6'd1);
		send_item(FN_SET, 5'd0, 16'h7FFF, 32'h2222_2222);
		send_item(FN_GET, 5'd0, 16'h7FFF, 32'h0);
		send_item(FN_FLUSH, 5'd0, 16'h0000, 32'h0);
		settle();
	endtask

	// Every slot gets a key before any random lookup may scan it.
	task automatic test_load_all_slots();
		key_pool[0] = 16'h8000;
		key_pool[1] = 16'h7FFF;
		key_pool[2] = 16'h0000;
		key_pool[3] = 16'hFFFF;
		for (int i = 4; i < 8; i++)
			key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
		for (int i = 0; i < SLOTS; i++)
			send_item(FN_LOAD, i[4:0], pick_key(90), pick_data());
	endtask

	task automatic test_random_traffic(int first_phase, int last_phase);
		int act_tab [7] = '{32, 63, 5, 32, 1, 40, -1};
		int lim_tab [7] = '{32, 63, 0, 3, 1, -1, -1};
		int in_tab [7]  = '{30, 0, 50, 20, 60, 10, 30};
		int out_tab [7] = '{30, 40, 0, 50, 20, 10, 30};
		int r;
		logic [5:0] act;
		logic [5:0] lim;
		for (int p = first_phase; p <= last_phase; p++) begin
			settle();
			act = (act_tab[p] < 0) ? 6'($urandom_range(0, 63)) : 6'(act_tab[p]);
			lim = (lim_tab[p] < 0) ? 6'($urandom_range(0, 63)) : 6'(lim_tab[p]);
			set_config(act, lim);
			in_gap_pct = in_tab[p];
			out_stall_pct = out_tab[p];
			key_pool[4 + (p % 4)] = 16'($urandom_range(0, 16'hFFFF));
			for (int i = 0; i < 64; i++) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					send_item(FN_LOAD, 5'($urandom_range(0, 31)), pick_key(85), pick_data());
				else if (r < 60)
					send_item(FN_SET, 5'($urandom_range(0, 31)), pick_key(80), pick_data());
				else if (r < 90)
					send_item(FN_GET, 5'($urandom_range(0, 31)), pick_key(80), pick_data());
				else
					send_item(FN_FLUSH, 5'($urandom_range(0, 31)), pick_key(50), pick_data());
				if ($urandom_range(0, 99) < 2)
					wait_for_answers();
			end
		end
	endtask

	task automatic test_output_backlog();
		settle();
		in_gap_pct = 0;
		hold_request = 400;
		// The sender keeps offering while the receiver holds off, filling the block.
		for (int i = 0; i < 12; i++)
			send_item(FN_GET, 5'd0, pick_key(90), pick_data());
		send_item(FN_FLUSH, 5'd0, 16'h0000, 32'h0);
		send_item(FN_SET, 5'd0, pick_key(100), pick_data());
		wait_for_answers();
	endtask

	initial begin
		mismatches = 0;
		reset_table_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_key_extremes();
		test_minus_one_value();
		test_limit_below_count();
		test_load_all_slots();
		test_random_traffic(0, 3);
		test_output_backlog();
		test_random_traffic(4, 6);
		wait_for_answers();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Far above the slowest legal run: every flush full and every result stalled long.
	initial begin
		#60ms;
		$display("FAILURE");
		$finish;
	end

endmodule
